### sv/nearest_exemplar_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest exemplar classifier
// Concurrent checks sampled on the rising clock edge, muted while in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_EXEMPLAR_CLASSIFIER_UNIT_ASSERT_SVH
`define NEAREST_EXEMPLAR_CLASSIFIER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define NEC_ASSERT_SAME(name_, clk_, rst_n_, ante_, cons_) \
    name_: assert property (@(posedge clk_) disable iff (!rst_n_) (ante_) |-> (cons_)) \
        else $error("nec check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent
`define NEC_ASSERT_NEXT(name_, clk_, rst_n_, ante_, cons_) \
    name_: assert property (@(posedge clk_) disable iff (!rst_n_) (ante_) |=> (cons_)) \
        else $error("nec check failed one cycle later");

`endif

### sv/nec_pkg.sv
// ----------------------------------------------------------------------------
// nec_pkg
// Shared codes, types and field widths of the nearest exemplar classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package nec_pkg;

    // Fixed field widths
    localparam int OP_BITS    = 2;
    localparam int LABEL_BITS = 4;
    localparam int KIND_BITS  = 2;
    localparam int COUNT_BITS = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;

    // Operation codes, read on the first element of a vector
    localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NONE  = 2'd3;

    // Result kinds
    localparam logic [KIND_BITS-1:0] KIND_ADD_ACK   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_PREDICT   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR_ACK = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_VECTOR_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LABEL_COUNT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FALLBACK_LABEL = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_SWEEP = 2'b10
    } nec_state_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic write_elem;   // add element: selected cell stores it
        logic write_label;  // add accepted: selected cell stores the label
        logic acc_en;       // squared difference in flight is added
        logic acc_first;    // ... and restarts the distance
    } nec_cell_ctrl_t;

    // One result item
    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic                  status;
        logic [LABEL_BITS-1:0] predicted_label;
        logic [COUNT_BITS-1:0] stored_count;
    } nec_result_t;

endpackage

`default_nettype wire

### sv/nearest_exemplar_classifier_unit.sv
// Add results are queued when an add's last element is taken, clear results when the clear item is taken.
// A query result is queued once the nearest pass has crossed the cell row.
// Throughput: 1 element per cycle while the result queue has room; after a query's last element the
// input stalls while the nearest pass crosses the cell row.
// Reset: table emptied, vector position at start, registers at defaults;
// exemplar storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// nearest_exemplar_classifier_unit
// One-nearest-neighbor classifier on squared Euclidean distance, built as a
// row of exemplar cells fed one feature element per item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_exemplar_classifier_unit_assert.svh"

module nearest_exemplar_classifier_unit #(
    parameter int MAX_EXEMPLARS = 64,
    parameter int MAX_LENGTH    = 16,
    parameter int MAX_LABELS    = 16,
    parameter int FEATURE_BITS  = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [nec_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [nec_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // sample items
    input  wire                                  sample_valid,
    output logic                                 sample_stall,
    input  wire  [nec_pkg::OP_BITS-1:0]          op,
    input  wire signed [FEATURE_BITS-1:0]        feature,
    input  wire  [nec_pkg::LABEL_BITS-1:0]       label,
    // result items
    output logic                                 result_valid,
    input  wire                                  result_stall,
    output logic [nec_pkg::KIND_BITS-1:0]        kind,
    output logic                                 status,
    output logic [nec_pkg::LABEL_BITS-1:0]       predicted_label,
    output logic [nec_pkg::COUNT_BITS-1:0]       stored_count
);

    localparam int CNT_W     = $clog2(MAX_EXEMPLARS + 1);
    localparam int POS_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int DIST_W    = (2 * FEATURE_BITS + 5 > 64) ? 64 : 2 * FEATURE_BITS + 5;
    localparam int SWEEP_LEN = MAX_EXEMPLARS + 1;
    localparam int SW_W      = $clog2(SWEEP_LEN + 1);

    // Configuration registers
    logic [4:0]                     vector_length_reg;
    logic [4:0]                     label_count_reg;
    logic [nec_pkg::LABEL_BITS-1:0] fallback_label_reg;

    // Sequencer state
    nec_pkg::nec_state_t state_reg;
    nec_pkg::nec_state_t state_next;
    logic [3:0]          pos_reg;
    logic [3:0]          pos_next;
    logic                query_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [SW_W-1:0]     sweep_cnt_reg;
    logic [SW_W-1:0]     sweep_cnt_next;
    logic                acc_vld_reg;
    logic                acc_first_reg;

    // Decode
    logic                accept;
    logic                at_start;
    logic                op_clear;
    logic                op_skip;
    logic                is_query;
    logic                vec_step;
    logic                add_step;
    logic                query_step;
    logic [6:0]          len_eff;
    logic                last;
    logic                label_ok;
    logic                full;
    logic                add_done;
    logic                add_ok;
    logic                sweep_done;
    logic [POS_W-1:0]    pos_idx;

    // Result path
    logic                 push;
    nec_pkg::nec_result_t push_data;
    nec_pkg::nec_result_t head_data;
    logic                 q_full;

    nec_pkg::nec_cell_ctrl_t cell_ctrl;

    // Cell row links; link 0 is the empty start of the row
    logic                           chain_have  [MAX_EXEMPLARS+1];
    logic [DIST_W-1:0]              chain_dist  [MAX_EXEMPLARS+1];
    logic [nec_pkg::LABEL_BITS-1:0] chain_label [MAX_EXEMPLARS+1];

    // Configuration writes are taken at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg  <= 5'd1;
            label_count_reg    <= 5'd1;
            fallback_label_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                nec_pkg::REG_VECTOR_LENGTH:  vector_length_reg  <= cfg_data;
                nec_pkg::REG_LABEL_COUNT:    label_count_reg    <= cfg_data;
                nec_pkg::REG_FALLBACK_LABEL:
                    fallback_label_reg <= cfg_data[nec_pkg::LABEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Item decode
    assign sample_stall = (state_reg != nec_pkg::ST_RUN) || q_full;
    assign accept       = sample_valid && !sample_stall;
    assign at_start     = (pos_reg == 4'd0);
    assign op_clear     = at_start && (op == nec_pkg::OP_CLEAR);
    assign op_skip      = at_start && (op == nec_pkg::OP_NONE);
    assign is_query     = at_start ? (op == nec_pkg::OP_QUERY) : query_reg;
    assign vec_step     = accept && !op_clear && !op_skip;
    assign add_step     = vec_step && !is_query;
    assign query_step   = vec_step && is_query;

    // Effective vector length, clamped to 1..MAX_LENGTH
    always_comb
    begin
        if (vector_length_reg == 5'd0)
            len_eff = 7'd1;
        else if (32'(vector_length_reg) > MAX_LENGTH)
            len_eff = 7'(MAX_LENGTH);
        else
            len_eff = 7'(vector_length_reg);
    end

    assign last = ((7'(pos_reg) + 7'd1) >= len_eff);

    // Element slot in the cells, clamped to the storage depth
    assign pos_idx = (32'(pos_reg) >= MAX_LENGTH) ? POS_W'(MAX_LENGTH - 1)
                                                  : POS_W'(pos_reg);

    // Add bookkeeping
    assign label_ok = (5'(label) < label_count_reg) && (32'(label) < MAX_LABELS);
    assign full     = (count_reg >= CNT_W'(MAX_EXEMPLARS));
    assign add_done = add_step && last;
    assign add_ok   = add_done && label_ok && !full;

    assign sweep_done = (state_reg == nec_pkg::ST_SWEEP)
                     && (sweep_cnt_reg == SW_W'(SWEEP_LEN));

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        if (vec_step)
            pos_next = last ? 4'd0 : pos_reg + 4'd1;
        if (accept && op_clear)
            count_next = '0;
        else if (add_ok)
            count_next = count_reg + CNT_W'(1);
        case (state_reg)
            nec_pkg::ST_RUN:
            begin
                if (query_step && last)
                begin
                    state_next     = nec_pkg::ST_SWEEP;
                    sweep_cnt_next = '0;
                end
            end
            nec_pkg::ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + SW_W'(1);
                if (sweep_done)
                    state_next = nec_pkg::ST_RUN;
            end
            default:
                state_next = nec_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nec_pkg::ST_RUN;
            sweep_cnt_reg <= '0;
            pos_reg       <= '0;
            query_reg     <= 1'b0;
            count_reg     <= '0;
            acc_vld_reg   <= 1'b0;
            acc_first_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            acc_vld_reg   <= query_step;
            acc_first_reg <= query_step && at_start;
            if (vec_step && at_start)
                query_reg <= is_query;
        end
    end

    // Cell row
    assign cell_ctrl.write_elem  = add_step;
    assign cell_ctrl.write_label = add_ok;
    assign cell_ctrl.acc_en      = acc_vld_reg;
    assign cell_ctrl.acc_first   = acc_first_reg;

    assign chain_have[0]  = 1'b0;
    assign chain_dist[0]  = '0;
    assign chain_label[0] = '0;

    for (genvar k = 0; k < MAX_EXEMPLARS; k++)
    begin : g_cell
        nec_cell #(
            .FEATURE_BITS (FEATURE_BITS),
            .MAX_LENGTH   (MAX_LENGTH),
            .CNT_W        (CNT_W),
            .DIST_W       (DIST_W),
            .INDEX        (k),
            .POS_W        (POS_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .entry_count (count_reg),
            .pos_idx     (pos_idx),
            .feature     (feature),
            .label       (label),
            .prev_have   (chain_have[k]),
            .prev_dist   (chain_dist[k]),
            .prev_label  (chain_label[k]),
            .best_have   (chain_have[k+1]),
            .best_dist   (chain_dist[k+1]),
            .best_label  (chain_label[k+1])
        );
    end

    // Result assembly
    assign push = (accept && op_clear) || add_done || sweep_done;

    always_comb
    begin
        push_data.kind            = nec_pkg::KIND_ADD_ACK;
        push_data.status          = 1'b0;
        push_data.predicted_label = '0;
        push_data.stored_count    = nec_pkg::COUNT_BITS'(count_reg);
        if (sweep_done)
        begin
            push_data.kind            = nec_pkg::KIND_PREDICT;
            push_data.predicted_label = chain_have[MAX_EXEMPLARS]
                                      ? chain_label[MAX_EXEMPLARS]
                                      : fallback_label_reg;
        end
        else if (op_clear)
        begin
            push_data.kind         = nec_pkg::KIND_CLEAR_ACK;
            push_data.stored_count = '0;
        end
        else
        begin
            push_data.status       = !add_ok;
            push_data.stored_count = nec_pkg::COUNT_BITS'(count_next);
        end
    end

    nec_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .head_valid (result_valid),
        .head_stall (result_stall),
        .head_data  (head_data)
    );

    assign kind            = head_data.kind;
    assign status          = head_data.status;
    assign predicted_label = head_data.predicted_label;
    assign stored_count    = head_data.stored_count;

    // Checks
    `NEC_ASSERT_SAME(a_sweep_blocks_input, clk, rst_n, state_reg == nec_pkg::ST_SWEEP, sample_stall)
    `NEC_ASSERT_SAME(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_EXEMPLARS))
    `NEC_ASSERT_SAME(a_push_has_room, clk, rst_n, push, !q_full)
    `NEC_ASSERT_NEXT(a_query_end_sweeps, clk, rst_n, query_step && last, state_reg == nec_pkg::ST_SWEEP)
    `NEC_ASSERT_NEXT(a_clear_empties, clk, rst_n, accept && op_clear, count_reg == '0)

endmodule

`default_nettype wire

### sv/nec_cell.sv
// ----------------------------------------------------------------------------
// nec_cell
// One exemplar slot: holds its elements and label, accumulates the squared
// distance to a streamed query and passes the running nearest to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_cell #(
    parameter int FEATURE_BITS = 16,
    parameter int MAX_LENGTH   = 16,
    parameter int CNT_W        = 7,
    parameter int DIST_W       = 37,
    parameter int INDEX        = 0,
    parameter int POS_W        = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire nec_pkg::nec_cell_ctrl_t          ctrl,
    input  wire        [CNT_W-1:0]                entry_count,
    input  wire        [POS_W-1:0]                pos_idx,
    input  wire signed [FEATURE_BITS-1:0]         feature,
    input  wire        [nec_pkg::LABEL_BITS-1:0]  label,
    input  wire                                   prev_have,
    input  wire        [DIST_W-1:0]               prev_dist,
    input  wire        [nec_pkg::LABEL_BITS-1:0]  prev_label,
    output logic                                  best_have,
    output logic       [DIST_W-1:0]               best_dist,
    output logic       [nec_pkg::LABEL_BITS-1:0]  best_label
);

    localparam int SQ_W  = 2 * (FEATURE_BITS + 1);
    localparam int SUM_W = ((DIST_W > SQ_W) ? DIST_W : SQ_W) + 1;

    logic signed [FEATURE_BITS-1:0]        elem_reg [MAX_LENGTH];
    logic        [nec_pkg::LABEL_BITS-1:0] label_reg;
    logic        [SQ_W-1:0]                sq_reg;
    logic        [DIST_W-1:0]              dist_reg;
    logic        [DIST_W-1:0]              dist_next;
    logic        [DIST_W-1:0]              best_dist_reg;
    logic        [nec_pkg::LABEL_BITS-1:0] best_label_reg;
    logic                                  best_have_reg;

    logic                                  selected;
    logic                                  occupied;
    logic signed [FEATURE_BITS:0]          diff;
    logic        [FEATURE_BITS:0]          mag;
    logic        [SQ_W-1:0]                sq_comb;
    logic        [DIST_W-1:0]              base;
    logic        [SUM_W-1:0]               sum;
    logic                                  take;

    assign selected = (CNT_W'(INDEX) == entry_count);
    assign occupied = (CNT_W'(INDEX) <  entry_count);

    // Stage one: absolute difference and its square
    assign diff    = {feature[FEATURE_BITS-1], feature}
                   - {elem_reg[pos_idx][FEATURE_BITS-1], elem_reg[pos_idx]};
    assign mag     = diff[FEATURE_BITS] ? $unsigned(-diff) : $unsigned(diff);
    assign sq_comb = mag * mag;

    // Stage two: saturating accumulate
    assign base = ctrl.acc_first ? '0 : dist_reg;
    assign sum  = SUM_W'(base) + SUM_W'(sq_reg);
    always_comb
    begin
        if (|sum[SUM_W-1:DIST_W])
            dist_next = '1;
        else
            dist_next = sum[DIST_W-1:0];
    end

    // Nearest so far: strictly smaller wins, so the lower index keeps ties
    assign take = occupied && (!prev_have || (dist_reg < prev_dist));

    // Exemplar storage
    always_ff @(posedge clk)
    begin
        if (ctrl.write_elem && selected)
            elem_reg[pos_idx] <= feature;
        if (ctrl.write_label && selected)
            label_reg <= label;
        sq_reg <= sq_comb;
    end

    // Distance and chain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg       <= '0;
            best_have_reg  <= 1'b0;
            best_dist_reg  <= '0;
            best_label_reg <= '0;
        end
        else
        begin
            if (ctrl.acc_en)
                dist_reg <= dist_next;
            best_have_reg  <= prev_have | occupied;
            best_dist_reg  <= take ? dist_reg  : prev_dist;
            best_label_reg <= take ? label_reg : prev_label;
        end
    end

    assign best_have  = best_have_reg;
    assign best_dist  = best_dist_reg;
    assign best_label = best_label_reg;

endmodule

`default_nettype wire

### sv/nec_result_queue.sv
// ----------------------------------------------------------------------------
// nec_result_queue
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_result_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  wire nec_pkg::nec_result_t push_data,
    output logic                 full,
    output logic                 head_valid,
    input  wire                  head_stall,
    output nec_pkg::nec_result_t head_data
);

    nec_pkg::nec_result_t head_reg;
    nec_pkg::nec_result_t tail_reg;
    logic                 head_vld_reg;
    logic                 tail_vld_reg;
    logic                 pop;

    assign pop = head_vld_reg && !head_stall;

    // Payload movement
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!head_vld_reg || (pop && !tail_vld_reg))
                head_reg <= push_data;
            else if (pop)
            begin
                head_reg <= tail_reg;
                tail_reg <= push_data;
            end
            else
                tail_reg <= push_data;
        end
        else if (pop)
            head_reg <= tail_reg;
    end

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            tail_vld_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                if (!head_vld_reg || (pop && !tail_vld_reg))
                    head_vld_reg <= 1'b1;
                else if (!pop)
                    tail_vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                head_vld_reg <= tail_vld_reg;
                tail_vld_reg <= 1'b0;
            end
        end
    end

    assign full       = tail_vld_reg;
    assign head_valid = head_vld_reg;
    assign head_data  = head_reg;

endmodule

`default_nettype wire
